/* hw/rtl/clns_pkg.sv */
// Shared types, constants and helpers of the character LCD nibble sequencer.
`default_nettype none

package clns_pkg;

    localparam logic [1:0] OP_INIT  = 2'd0;
    localparam logic [1:0] OP_SEND  = 2'd1;
    localparam logic [1:0] OP_REPLY = 2'd2;

    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_READ  = 1'b1;

    // Expander port bits
    localparam logic [7:0] PORT_RS = 8'h01;
    localparam logic [7:0] PORT_EN = 8'h02;
    localparam logic [7:0] PORT_RW = 8'h04;

    localparam logic [3:0] WAKE_NIB     = 4'h3;
    localparam logic [3:0] FOUR_BIT_NIB = 4'h2;
    localparam logic [2:0] INIT_LAST_STEP = 3'd5;

    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_SEND,
        PH_INIT
    } phase_t;

    typedef enum logic [1:0] {
        BODY_NONE,
        BODY_WAKE,
        BODY_NIB2,
        BODY_BYTE
    } body_t;

    typedef enum logic [1:0] {
        SEG_IDLE,
        SEG_FIN,
        SEG_BODY,
        SEG_POLL
    } seg_t;

    // One queued job: close a read, play a body, open a poll
    typedef struct packed {
        logic       fin;
        body_t      body;
        logic       poll;
        logic       done;
        logic [3:0] fin_nib;
        logic [3:0] poll_nib;
        logic [7:0] data;
        logic       rs;
    } job_t;

    function automatic logic [7:0] init_cmd(input logic [1:0] idx);
        logic [7:0] cmd;
        case (idx)
            2'd0:    cmd = 8'h28;
            2'd1:    cmd = 8'h0C;
            2'd2:    cmd = 8'h01;
            default: cmd = 8'h06;
        endcase
        return cmd;
    endfunction

    function automatic seg_t first_seg(input job_t job);
        seg_t s;
        if (job.fin)
            s = SEG_FIN;
        else if (job.body != BODY_NONE)
            s = SEG_BODY;
        else
            s = SEG_POLL;
        return s;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/clns_ifs.sv */
// Valid/ready channel interfaces for input and result items.
`default_nettype none

interface clns_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] op;
    logic [7:0] data_byte;
    logic       is_data;
    logic [7:0] port_value;

    modport source (output valid, output op, output data_byte, output is_data,
                    output port_value, input ready);
    modport sink (input valid, input op, input data_byte, input is_data,
                  input port_value, output ready);
endinterface

interface clns_out_if;
    logic       valid;
    logic       ready;
    logic       action;
    logic [7:0] port_byte;
    logic       last;
    logic       done_res;

    modport source (output valid, output action, output port_byte, output last,
                    output done_res, input ready);
    modport sink (input valid, input action, input port_byte, input last,
                  input done_res, output ready);
endinterface

`default_nettype wire

/* hw/rtl/char_lcd_nibble_sequencer_top.sv */
// Top level of the character LCD nibble sequencer.
//
//  channel    dir  payload                                   accepted when
//  in_item    in   op, data_byte, is_data, port_value        valid && ready
//  out_item   out  action, port_byte, last, done_res         valid && ready
//
// Each item yields 0 to 13 results, issued by the back end one per cycle unless the output stalls.
// An item is taken every cycle while the job queue has room; the back end
// sequencer (one expander access per cycle unless stalled) sets sustained throughput.
// Reset clears phase, queue and sequencer at once; no clearing pass.
// A stalled output holds its register; the queue lets the front keep going.
`default_nettype none

module char_lcd_nibble_sequencer_top #(
    parameter int QUEUE_DEPTH = clns_pkg::QUEUE_DEPTH
) (
    input  wire         clk,
    input  wire         rst_n,
    clns_in_if.sink     in_item,
    clns_out_if.source  out_item
);
    import clns_pkg::*;

    logic push_valid, push_ready;
    logic pop_valid, pop_ready;
    job_t push_job, pop_job;

    clns_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_item    (in_item),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job)
    );

    clns_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_job    (pop_job)
    );

    clns_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_job   (pop_job),
        .out_item  (out_item)
    );

endmodule

`default_nettype wire

/* hw/rtl/clns_front.sv */
// Front end: accepts items, tracks the sequence phase and builds jobs.
`default_nettype none

module clns_front (
    input  wire            clk,
    input  wire            rst_n,
    clns_in_if.sink        in_item,
    output logic           push_valid,
    input  wire            push_ready,
    output clns_pkg::job_t push_job
);
    import clns_pkg::*;

    phase_t     phase_reg, phase_next;
    logic [2:0] step_reg, step_next;
    logic [3:0] nib_reg, nib_next;
    logic       accept;
    logic       has_job;
    job_t       job;
    logic [7:0] cmd;

    assign in_item.ready = push_ready;
    assign accept        = in_item.valid && push_ready;
    assign push_valid    = in_item.valid && has_job;
    assign push_job      = job;
    assign cmd           = init_cmd(2'(step_reg - 3'd1));

    always_comb
    begin
        phase_next   = phase_reg;
        step_next    = step_reg;
        nib_next     = nib_reg;
        has_job      = 1'b0;
        job          = '0;
        job.body     = BODY_NONE;
        job.fin_nib  = nib_reg;
        job.data     = in_item.data_byte;
        job.rs       = in_item.is_data;
        if (in_item.op == OP_INIT && phase_reg == PH_IDLE)
        begin
            has_job      = 1'b1;
            job.body     = BODY_WAKE;
            job.poll     = 1'b1;
            job.poll_nib = WAKE_NIB;
            phase_next   = PH_INIT;
            step_next    = 3'd0;
            nib_next     = WAKE_NIB;
        end
        else if (in_item.op == OP_SEND && phase_reg == PH_IDLE)
        begin
            has_job      = 1'b1;
            job.body     = BODY_BYTE;
            job.poll     = 1'b1;
            job.poll_nib = in_item.data_byte[3:0];
            phase_next   = PH_SEND;
            nib_next     = in_item.data_byte[3:0];
        end
        else if (in_item.op == OP_REPLY && phase_reg != PH_IDLE)
        begin
            has_job = 1'b1;
            job.fin = 1'b1;
            if (in_item.port_value[7])
            begin
                job.poll     = 1'b1;
                job.poll_nib = nib_reg;
            end
            else if (phase_reg == PH_SEND || step_reg >= INIT_LAST_STEP)
            begin
                job.done   = 1'b1;
                phase_next = PH_IDLE;
            end
            else
            begin
                step_next = step_reg + 3'd1;
                job.poll  = 1'b1;
                if (step_reg == 3'd0)
                begin
                    job.body     = BODY_NIB2;
                    job.poll_nib = FOUR_BIT_NIB;
                    nib_next     = FOUR_BIT_NIB;
                end
                else
                begin
                    job.body     = BODY_BYTE;
                    job.data     = cmd;
                    job.rs       = 1'b0;
                    job.poll_nib = cmd[3:0];
                    nib_next     = cmd[3:0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            step_reg  <= 3'd0;
            nib_reg   <= 4'd0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            step_reg  <= step_next;
            nib_reg   <= nib_next;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/clns_fifo.sv */
// Small job queue between front end and back end.
`default_nettype none

module clns_fifo #(
    parameter int DEPTH = clns_pkg::QUEUE_DEPTH
) (
    input  wire            clk,
    input  wire            rst_n,
    input  wire            push_valid,
    output logic           push_ready,
    input  clns_pkg::job_t push_job,
    output logic           pop_valid,
    input  wire            pop_ready,
    output clns_pkg::job_t pop_job
);
    import clns_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    job_t          mem [DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic          push, pop;

    assign push_ready = count_reg != CW'(DEPTH);
    assign pop_valid  = count_reg != '0;
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_job    = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/clns_back.sv */
// Back end: expands a job into expander accesses, one per cycle unless the output stalls.
`default_nettype none

module clns_back (
    input  wire            clk,
    input  wire            rst_n,
    input  wire            pop_valid,
    output logic           pop_ready,
    input  clns_pkg::job_t pop_job,
    clns_out_if.source     out_item
);
    import clns_pkg::*;

    localparam logic [2:0] FIN_LAST  = 3'd3;
    localparam logic [2:0] POLL_LAST = 3'd2;
    localparam logic [2:0] BYTE_LAST = 3'd5;
    localparam logic [2:0] NIB2_LAST = 3'd1;

    seg_t       seg_reg, seg_next;
    logic [2:0] cnt_reg, cnt_next;
    job_t       job_reg;
    logic       advance, pop_fire, seg_end, job_end;
    logic [2:0] body_last;
    logic       act;
    logic [7:0] pbyte;
    logic       out_valid_reg;
    logic       out_action_reg;
    logic [7:0] out_byte_reg;
    logic       out_last_reg;
    logic       out_done_reg;

    assign advance   = (seg_reg != SEG_IDLE) && (!out_valid_reg || out_item.ready);
    assign pop_ready = (seg_reg == SEG_IDLE) || (advance && job_end);
    assign pop_fire  = pop_valid && pop_ready;
    assign body_last = (job_reg.body == BODY_NIB2) ? NIB2_LAST : BYTE_LAST;

    always_comb
    begin
        case (seg_reg)
            SEG_FIN:
            begin
                seg_end = cnt_reg == FIN_LAST;
                job_end = seg_end && job_reg.body == BODY_NONE && !job_reg.poll;
            end
            SEG_BODY:
            begin
                seg_end = cnt_reg == body_last;
                job_end = seg_end && !job_reg.poll;
            end
            SEG_POLL:
            begin
                seg_end = cnt_reg == POLL_LAST;
                job_end = seg_end;
            end
            default:
            begin
                seg_end = 1'b0;
                job_end = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        seg_next = seg_reg;
        cnt_next = cnt_reg;
        if (pop_fire)
        begin
            seg_next = first_seg(pop_job);
            cnt_next = 3'd0;
        end
        else if (advance)
        begin
            if (job_end)
                seg_next = SEG_IDLE;
            else if (seg_end)
            begin
                if (seg_reg == SEG_FIN && job_reg.body != BODY_NONE)
                    seg_next = SEG_BODY;
                else
                    seg_next = SEG_POLL;
                cnt_next = 3'd0;
            end
            else
                cnt_next = cnt_reg + 3'd1;
        end
    end

    always_comb
    begin
        act   = ACT_WRITE;
        pbyte = 8'h00;
        case (seg_reg)
            SEG_FIN:
            begin
                pbyte = {job_reg.fin_nib, 4'h0};
                if (cnt_reg != FIN_LAST)
                    pbyte = pbyte | PORT_RW;
                if (cnt_reg == 3'd1)
                    pbyte = pbyte | PORT_EN;
            end
            SEG_BODY:
            begin
                case (job_reg.body)
                    BODY_WAKE:
                        pbyte = {WAKE_NIB, 4'h0} | (cnt_reg[0] ? 8'h00 : PORT_EN);
                    BODY_NIB2:
                        pbyte = {FOUR_BIT_NIB, 4'h0} | (cnt_reg[0] ? 8'h00 : PORT_EN);
                    BODY_BYTE:
                    begin
                        pbyte = {(cnt_reg < 3'd3) ? job_reg.data[7:4] : job_reg.data[3:0],
                                 4'h0};
                        if (job_reg.rs)
                            pbyte = pbyte | PORT_RS;
                        if (cnt_reg inside {3'd1, 3'd4})
                            pbyte = pbyte | PORT_EN;
                    end
                    default:
                        pbyte = 8'h00;
                endcase
            end
            SEG_POLL:
            begin
                pbyte = {job_reg.poll_nib, 4'h0} | PORT_RW;
                if (cnt_reg != 3'd0)
                    pbyte = pbyte | PORT_EN;
                if (cnt_reg == POLL_LAST)
                    act = ACT_READ;
            end
            default:
            begin
                act   = ACT_WRITE;
                pbyte = 8'h00;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (pop_fire)
            job_reg <= pop_job;
        if (advance)
        begin
            out_action_reg <= act;
            out_byte_reg   <= pbyte;
            out_last_reg   <= job_end;
            out_done_reg   <= job_end && job_reg.done;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seg_reg       <= SEG_IDLE;
            cnt_reg       <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            seg_reg <= seg_next;
            cnt_reg <= cnt_next;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (out_item.ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign out_item.valid     = out_valid_reg;
    assign out_item.action    = out_action_reg;
    assign out_item.port_byte = out_byte_reg;
    assign out_item.last      = out_last_reg;
    assign out_item.done_res  = out_done_reg;

endmodule

`default_nettype wire

/* test/char_lcd_nibble_sequencer_top_tb.sv */
// Self-checking testbench of the character LCD nibble sequencer top level.
`timescale 1ns / 1ps

module char_lcd_nibble_sequencer_top_tb;

    import clns_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam logic [7:0] POWER_UP_CMDS [4] = '{8'h28, 8'h0C, 8'h01, 8'h06};

    typedef struct packed {
        logic       action;
        logic [7:0] port_byte;
        logic       last;
        logic       done_res;
    } access_t;

    logic clk;
    logic rst_n;

    clns_in_if  in_if ();
    clns_out_if out_if ();

    char_lcd_nibble_sequencer_top DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_item  (in_if),
        .out_item (out_if)
    );

    access_t    expected_accesses [$];
    access_t    item_accesses [$];
    logic [7:0] shadow;
    phase_t     phase;
    logic [2:0] init_step;

    int error_count;
    bit in_idle_en;
    bit out_idle_en;
    int hold_len;
    int hold_id;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("char_lcd_nibble_sequencer_top regression: fail");
        $finish;
    end

    // Predictor of the expander accesses
    function automatic void emit_access(input logic act);
        access_t a;
        a.action    = act;
        a.port_byte = shadow;
        a.last      = 1'b0;
        a.done_res  = 1'b0;
        item_accesses.push_back(a);
    endfunction

    function automatic void pulse_en();
        shadow = shadow | PORT_EN;
        emit_access(ACT_WRITE);
        shadow = shadow & ~PORT_EN;
        emit_access(ACT_WRITE);
    endfunction

    function automatic void write_byte(input logic [7:0] b, input logic rs);
        shadow = rs ? (shadow | PORT_RS) : (shadow & ~PORT_RS);
        shadow = {b[7:4], shadow[3:0]};
        emit_access(ACT_WRITE);
        pulse_en();
        shadow = {b[3:0], shadow[3:0]};
        emit_access(ACT_WRITE);
        pulse_en();
    endfunction

    function automatic void open_poll();
        shadow = shadow & ~PORT_RS;
        shadow = shadow | PORT_RW;
        emit_access(ACT_WRITE);
        shadow = shadow | PORT_EN;
        emit_access(ACT_WRITE);
        emit_access(ACT_READ);
    endfunction

    function automatic void close_poll();
        shadow = shadow & ~PORT_EN;
        emit_access(ACT_WRITE);
        pulse_en();
        shadow = shadow & ~PORT_RW;
        emit_access(ACT_WRITE);
    endfunction

    function automatic int predict_lcd_accesses(input logic [1:0] op, input logic [7:0] data,
                                                input logic rs, input logic [7:0] pv);
        logic    finished;
        access_t tail;
        finished = 1'b0;
        item_accesses.delete();
        if (op == OP_INIT && phase == PH_IDLE)
        begin
            shadow = {WAKE_NIB, 4'h0};
            pulse_en();
            pulse_en();
            pulse_en();
            open_poll();
            init_step = 3'd0;
            phase = PH_INIT;
        end
        else if (op == OP_SEND && phase == PH_IDLE)
        begin
            write_byte(data, rs);
            open_poll();
            phase = PH_SEND;
        end
        else if (op == OP_REPLY && phase != PH_IDLE)
        begin
            close_poll();
            if (pv[7])
                open_poll();
            else if (phase == PH_SEND || init_step >= INIT_LAST_STEP)
            begin
                phase = PH_IDLE;
                finished = 1'b1;
            end
            else
            begin
                init_step = init_step + 3'd1;
                if (init_step == 3'd1)
                begin
                    shadow = {FOUR_BIT_NIB, 4'h0};
                    pulse_en();
                end
                else
                    write_byte(POWER_UP_CMDS[2'(init_step - 3'd2)], 1'b0);
                open_poll();
            end
        end
        if (item_accesses.size() > 0)
        begin
            tail = item_accesses.pop_back();
            tail.last = 1'b1;
            tail.done_res = finished;
            item_accesses.push_back(tail);
        end
        foreach (item_accesses[i])
            expected_accesses.push_back(item_accesses[i]);
        return item_accesses.size();
    endfunction

    // Result checker
    always @(posedge clk)
    begin : check_results
        access_t want;
        if (rst_n && out_if.valid && out_if.ready)
        begin
            if (expected_accesses.size() == 0)
            begin
                $error("unexpected result: action %0d port_byte %h", out_if.action,
                       out_if.port_byte);
                error_count++;
            end
            else
            begin
                want = expected_accesses.pop_front();
                if (out_if.action !== want.action)
                begin
                    $error("action: expected %0d, got %0d", want.action, out_if.action);
                    error_count++;
                end
                if (out_if.port_byte !== want.port_byte)
                begin
                    $error("port_byte: expected %h, got %h", want.port_byte, out_if.port_byte);
                    error_count++;
                end
                if (out_if.last !== want.last)
                begin
                    $error("last: expected %0d, got %0d", want.last, out_if.last);
                    error_count++;
                end
                if (out_if.done_res !== want.done_res)
                begin
                    $error("done_res: expected %0d, got %0d", want.done_res, out_if.done_res);
                    error_count++;
                end
            end
        end
    end

    // Receiver: random stalls plus a long hold-off on request
    initial
    begin : sink_ready
        int hold_left;
        int seen_id;
        hold_left = 0;
        seen_id = 0;
        out_if.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_id != seen_id)
            begin
                seen_id = hold_id;
                hold_left = hold_len;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_if.ready <= 1'b0;
            end
            else if (out_idle_en)
                out_if.ready <= ($urandom_range(99) >= 30);
            else
                out_if.ready <= 1'b1;
        end
    end

    task automatic send_item(input logic [1:0] op, input logic [7:0] data, input logic rs,
                             input logic [7:0] pv, output int n);
        if (in_idle_en && $urandom_range(99) < 30)
        begin
            in_if.valid <= 1'b0;
            repeat ($urandom_range(2, 1)) @(posedge clk);
        end
        in_if.valid      <= 1'b1;
        in_if.op         <= op;
        in_if.data_byte  <= data;
        in_if.is_data    <= rs;
        in_if.port_value <= pv;
        @(posedge clk);
        while (!in_if.ready)
            @(posedge clk);
        n = predict_lcd_accesses(op, data, rs, pv);
    endtask

    task automatic wait_all_results();
        in_if.valid <= 1'b0;
        while (expected_accesses.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic test_ignored_when_idle();
        int n;
        send_item(OP_REPLY, 8'hFF, 1'b1, 8'h80, n);
        send_item(OP_REPLY, 8'h00, 1'b0, 8'h00, n);
        send_item(OP_UNUSED, 8'hFF, 1'b1, 8'hFF, n);
        wait_all_results();
    endtask

    task automatic test_init_sequence();
        int n;
        send_item(OP_INIT, 8'hC3, 1'b1, 8'h5A, n);
        send_item(OP_SEND, 8'h41, 1'b1, 8'h00, n);
        send_item(OP_INIT, 8'h00, 1'b0, 8'h00, n);
        send_item(OP_UNUSED, 8'h00, 1'b0, 8'h80, n);
        send_item(OP_REPLY, 8'h00, 1'b0, 8'hFF, n);
        repeat (6) send_item(OP_REPLY, 8'($urandom_range(255)), 1'($urandom_range(1)), 8'h7F, n);
        wait_all_results();
    endtask

    task automatic test_send_extremes();
        int n;
        send_item(OP_SEND, 8'h00, 1'b0, 8'hFF, n);
        send_item(OP_REPLY, 8'hFF, 1'b1, 8'h7F, n);
        send_item(OP_SEND, 8'hFF, 1'b1, 8'h00, n);
        send_item(OP_REPLY, 8'h00, 1'b0, 8'hFF, n);
        send_item(OP_REPLY, 8'hFF, 1'b1, 8'h00, n);
        send_item(OP_SEND, 8'hA5, 1'b1, 8'h00, n);
        send_item(OP_REPLY, 8'h00, 1'b0, 8'h00, n);
        wait_all_results();
    endtask

    task automatic test_output_hold();
        int n;
        in_idle_en = 1'b0;
        hold_len = 150;
        hold_id++;
        send_item(OP_SEND, 8'h3C, 1'b1, 8'h00, n);
        repeat (8) send_item(OP_REPLY, 8'h00, 1'b0, 8'hC1, n);
        send_item(OP_REPLY, 8'h00, 1'b0, 8'h12, n);
        wait_all_results();
        in_idle_en = 1'b1;
    endtask

    task automatic test_random_traffic();
        int         taken;
        int         n;
        int         pick;
        logic [1:0] op;
        logic [7:0] pv;
        taken = 0;
        while (taken < 220)
        begin
            in_idle_en = !(taken >= 80 && taken < 150);
            out_idle_en = in_idle_en;
            pick = $urandom_range(99);
            pv = 8'($urandom_range(255));
            if (phase == PH_IDLE)
            begin
                if (pick < 10)
                    op = (pick < 5) ? OP_UNUSED : OP_REPLY;
                else if (pick < 28)
                    op = OP_INIT;
                else
                    op = OP_SEND;
            end
            else if (pick < 8)
            begin
                case ($urandom_range(2))
                    0:       op = OP_INIT;
                    1:       op = OP_SEND;
                    default: op = OP_UNUSED;
                endcase
            end
            else
            begin
                op = OP_REPLY;
                pv[7] = ($urandom_range(99) < 25);
            end
            send_item(op, 8'($urandom_range(255)), 1'($urandom_range(1)), pv, n);
            if (n > 0)
                taken++;
        end
        while (phase != PH_IDLE)
        begin
            pv = 8'($urandom_range(127));
            send_item(OP_REPLY, 8'($urandom_range(255)), 1'($urandom_range(1)), pv, n);
        end
        wait_all_results();
    endtask

    initial
    begin
        in_if.valid      = 1'b0;
        in_if.op         = OP_INIT;
        in_if.data_byte  = 8'h00;
        in_if.is_data    = 1'b0;
        in_if.port_value = 8'h00;
        shadow      = 8'h00;
        phase       = PH_IDLE;
        init_step   = 3'd0;
        error_count = 0;
        in_idle_en  = 1'b1;
        out_idle_en = 1'b1;
        hold_len    = 0;
        hold_id     = 0;
        rst_n       = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_ignored_when_idle();
        test_init_sequence();
        test_send_extremes();
        test_output_hold();
        test_random_traffic();
        if (error_count == 0)
            $display("char_lcd_nibble_sequencer_top regression: pass");
        else
            $display("char_lcd_nibble_sequencer_top regression: fail");
        $finish;
    end

endmodule
